### sv/irpdt_pkg.sv
// Shared types and constants for the infrared pulse-distance transmitter.
// Used by the top level and the frame byte shifter; depends on nothing.
package irpdt_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 16;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned GAP_W  = 20;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CFG_ADDR_W = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_LEADER_MARK  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEADER_SPACE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_MARK  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_SPACE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_SPACE   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BIT_MARK     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP          = 3'd6;

  // Reset timing in microseconds.
  localparam logic [TIME_W-1:0] RST_LEADER_MARK  = 16'd9000;
  localparam logic [TIME_W-1:0] RST_LEADER_SPACE = 16'd4500;
  localparam logic [TIME_W-1:0] RST_HEADER_MARK  = 16'd600;
  localparam logic [TIME_W-1:0] RST_ONE_SPACE    = 16'd1650;
  localparam logic [TIME_W-1:0] RST_ZERO_SPACE   = 16'd540;
  localparam logic [TIME_W-1:0] RST_BIT_MARK     = 16'd540;
  localparam logic [GAP_W-1:0]  RST_GAP          = 20'd500000;

  // Input operation codes (in tuser).
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Bit positions in the result word.
  localparam int unsigned OUT_CARRIER  = 0;
  localparam int unsigned OUT_BUSY     = 1;
  localparam int unsigned OUT_DONE     = 2;
  localparam int unsigned OUT_REJECTED = 3;
  localparam int unsigned OUT_FLDS     = 4;
  localparam int unsigned OUT_W        = 8;

  typedef enum logic [8:0] {
    PH_IDLE        = 9'b000000001,
    PH_LEADER_MARK = 9'b000000010,
    PH_LEADER_SPC  = 9'b000000100,
    PH_HEADER_MARK = 9'b000001000,
    PH_BIT_SPACE   = 9'b000010000,
    PH_BIT_MARK    = 9'b000100000,
    PH_GAP         = 9'b001000000,
    PH_FETCH_WAIT  = 9'b010000000,
    PH_FETCH_LOAD  = 9'b100000000
  } phase_t;

  // Control from the sequencer to the byte shifter.
  typedef struct packed {
    logic wr_en;
    logic load;
    logic shift;
  } shf_ctl_t;

  function automatic logic is_mark(input phase_t ph);
    return (ph == PH_LEADER_MARK) || (ph == PH_HEADER_MARK) || (ph == PH_BIT_MARK);
  endfunction

endpackage

### sv/irpdt_shifter.sv
// Frame byte store with a registered read port and the bit shift register
// that serializes the current byte LSB first. Depends on irpdt_pkg.
module irpdt_shifter #(
  parameter int unsigned DEPTH = irpdt_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned IDX_W = 4
) (
  input  logic                         clk,
  input  irpdt_pkg::shf_ctl_t          ctl,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic [irpdt_pkg::DATA_W-1:0] wr_data,
  input  logic [IDX_W-1:0]             rd_addr,
  output logic                         fetch_bit,
  output logic                         next_bit
);

  logic [irpdt_pkg::DATA_W-1:0] mem [DEPTH];
  logic [irpdt_pkg::DATA_W-1:0] rd_r;
  logic [irpdt_pkg::DATA_W-1:0] sh_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  // Load a fresh byte, or drop the bit just sent.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sh_r <= rd_r;
    end else if (ctl.shift) begin
      sh_r <= {1'b0, sh_r[irpdt_pkg::DATA_W-1:1]};
    end
  end

  assign fetch_bit = rd_r[0];
  assign next_bit  = sh_r[1];

endmodule

### sv/ir_pulse_distance_transmitter.sv
// Infrared pulse-distance frame transmitter: top level with the segment
// sequencer, timing registers and result register. Depends on irpdt_pkg
// and irpdt_shifter.
//
// Each input word is either a one-microsecond tick or a frame byte load
// (in_tuser); the load with in_tlast starts the frame. Every accepted word
// yields one result word. After a tick that opens a new byte of the frame,
// the input stalls in the fetch-wait and fetch-load states while the byte
// is read from the frame store into the bit shift register. Timing
// registers may only be written while no frame is running. The frame store
// has no reset; entries are read only after they were loaded.
module ir_pulse_distance_transmitter #(
  parameter int unsigned MAX_FRAME_BYTES = irpdt_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [irpdt_pkg::DATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,   // last_byte
  input  logic                             in_tuser,   // [0] operation
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] carrier_enable, [1] busy_res, [2] frame_done, [3] load_rejected
  output logic [irpdt_pkg::OUT_W-1:0]      out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [irpdt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [irpdt_pkg::GAP_W-1:0]      cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned IDX_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam int unsigned TW = irpdt_pkg::TIME_W;
  localparam int unsigned GW = irpdt_pkg::GAP_W;

  logic [TW-1:0] leader_mark_r, leader_space_r, header_mark_r;
  logic [TW-1:0] one_space_r, zero_space_r, bit_mark_r;
  logic [GW-1:0] gap_r;

  irpdt_pkg::phase_t phase_r, phase_nxt;
  logic [GW-1:0]     dur_r, dur_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [irpdt_pkg::OUT_FLDS-1:0] out_r, out_nxt;

  irpdt_pkg::shf_ctl_t ctl;
  logic fetch_bit, next_bit;
  logic acc, fetching;
  logic carrier, busy, done, rejected;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_mark_r  <= irpdt_pkg::RST_LEADER_MARK;
      leader_space_r <= irpdt_pkg::RST_LEADER_SPACE;
      header_mark_r  <= irpdt_pkg::RST_HEADER_MARK;
      one_space_r    <= irpdt_pkg::RST_ONE_SPACE;
      zero_space_r   <= irpdt_pkg::RST_ZERO_SPACE;
      bit_mark_r     <= irpdt_pkg::RST_BIT_MARK;
      gap_r          <= irpdt_pkg::RST_GAP;
    end else if (cfg_valid) begin
      case (cfg_addr)
        irpdt_pkg::REG_LEADER_MARK:  leader_mark_r  <= cfg_data[TW-1:0];
        irpdt_pkg::REG_LEADER_SPACE: leader_space_r <= cfg_data[TW-1:0];
        irpdt_pkg::REG_HEADER_MARK:  header_mark_r  <= cfg_data[TW-1:0];
        irpdt_pkg::REG_ONE_SPACE:    one_space_r    <= cfg_data[TW-1:0];
        irpdt_pkg::REG_ZERO_SPACE:   zero_space_r   <= cfg_data[TW-1:0];
        irpdt_pkg::REG_BIT_MARK:     bit_mark_r     <= cfg_data[TW-1:0];
        irpdt_pkg::REG_GAP:          gap_r          <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fetching  = (phase_r == irpdt_pkg::PH_FETCH_WAIT) ||
                     (phase_r == irpdt_pkg::PH_FETCH_LOAD);
  assign in_tready = !fetching && (!out_vld_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    phase_nxt = phase_r;
    dur_nxt   = dur_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    bit_nxt   = bit_r;
    ctl       = '0;
    carrier   = 1'b0;
    busy      = 1'b0;
    done      = 1'b0;
    rejected  = 1'b0;

    if (phase_r == irpdt_pkg::PH_FETCH_WAIT) begin
      // store read is in flight
      phase_nxt = irpdt_pkg::PH_FETCH_LOAD;
    end else if (phase_r == irpdt_pkg::PH_FETCH_LOAD) begin
      ctl.load  = 1'b1;
      phase_nxt = irpdt_pkg::PH_BIT_SPACE;
      dur_nxt   = GW'(fetch_bit ? one_space_r : zero_space_r);
    end else if (acc) begin
      if (in_tuser == irpdt_pkg::OP_LOAD) begin
        if (phase_r != irpdt_pkg::PH_IDLE || cnt_r >= CNT_W'(MAX_FRAME_BYTES)) begin
          rejected = 1'b1;
        end else begin
          ctl.wr_en = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          if (in_tlast) begin
            idx_nxt   = '0;
            bit_nxt   = '0;
            phase_nxt = irpdt_pkg::PH_LEADER_MARK;
            dur_nxt   = GW'(leader_mark_r);
          end
        end
        carrier = irpdt_pkg::is_mark(phase_nxt);
        busy    = phase_nxt != irpdt_pkg::PH_IDLE;
      end else if (phase_r != irpdt_pkg::PH_IDLE) begin
        carrier = irpdt_pkg::is_mark(phase_r);
        busy    = 1'b1;
        if (dur_r > GW'(1)) begin
          dur_nxt = dur_r - 1'b1;
        end else begin
          case (phase_r)
            irpdt_pkg::PH_LEADER_MARK: begin
              phase_nxt = irpdt_pkg::PH_LEADER_SPC;
              dur_nxt   = GW'(leader_space_r);
            end
            irpdt_pkg::PH_LEADER_SPC: begin
              phase_nxt = irpdt_pkg::PH_HEADER_MARK;
              dur_nxt   = GW'(header_mark_r);
            end
            irpdt_pkg::PH_HEADER_MARK: begin
              phase_nxt = irpdt_pkg::PH_FETCH_WAIT;
            end
            irpdt_pkg::PH_BIT_SPACE: begin
              phase_nxt = irpdt_pkg::PH_BIT_MARK;
              dur_nxt   = GW'(bit_mark_r);
            end
            irpdt_pkg::PH_BIT_MARK: begin
              if (bit_r == 3'd7) begin
                bit_nxt = '0;
                idx_nxt = idx_r + 1'b1;
                if (idx_nxt >= cnt_r) begin
                  phase_nxt = irpdt_pkg::PH_GAP;
                  dur_nxt   = gap_r;
                end else begin
                  phase_nxt = irpdt_pkg::PH_FETCH_WAIT;
                end
              end else begin
                // next bit of the same byte
                bit_nxt   = bit_r + 1'b1;
                ctl.shift = 1'b1;
                phase_nxt = irpdt_pkg::PH_BIT_SPACE;
                dur_nxt   = GW'(next_bit ? one_space_r : zero_space_r);
              end
            end
            irpdt_pkg::PH_GAP: begin
              done      = 1'b1;
              phase_nxt = irpdt_pkg::PH_IDLE;
              dur_nxt   = '0;
              cnt_nxt   = '0;
              idx_nxt   = '0;
              bit_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    out_nxt = out_r;
    out_vld_nxt = out_vld_r;
    if (acc) begin
      out_vld_nxt = 1'b1;
      out_nxt[irpdt_pkg::OUT_CARRIER]  = carrier;
      out_nxt[irpdt_pkg::OUT_BUSY]     = busy;
      out_nxt[irpdt_pkg::OUT_DONE]     = done;
      out_nxt[irpdt_pkg::OUT_REJECTED] = rejected;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= irpdt_pkg::PH_IDLE;
      dur_r     <= '0;
      cnt_r     <= '0;
      idx_r     <= '0;
      bit_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      dur_r     <= dur_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      bit_r     <= bit_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(irpdt_pkg::OUT_W - irpdt_pkg::OUT_FLDS){1'b0}}, out_r};

  irpdt_shifter #(
    .DEPTH (MAX_FRAME_BYTES),
    .IDX_W (IDX_W)
  ) u_shifter (
    .clk       (clk),
    .ctl       (ctl),
    .wr_addr   (cnt_r[IDX_W-1:0]),
    .wr_data   (in_tdata),
    .rd_addr   (idx_r[IDX_W-1:0]),
    .fetch_bit (fetch_bit),
    .next_bit  (next_bit)
  );

endmodule

### sv/irpdt_checker.sv
// Port-level checks for the infrared pulse-distance transmitter, bound to
// the top level. Depends on irpdt_pkg for the result word layout.
module irpdt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [irpdt_pkg::DATA_W-1:0]     in_tdata,
  input logic                             in_tlast,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [irpdt_pkg::OUT_W-1:0]      out_tdata,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [irpdt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input logic [irpdt_pkg::GAP_W-1:0]      cfg_data
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Carrier only runs inside a frame.
  a_carrier_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[irpdt_pkg::OUT_CARRIER] |-> out_tdata[irpdt_pkg::OUT_BUSY])
    else $error("carrier on while not busy");

  // Frame end is flagged on a busy tick with the carrier off.
  a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[irpdt_pkg::OUT_DONE] |->
      out_tdata[irpdt_pkg::OUT_BUSY] && !out_tdata[irpdt_pkg::OUT_CARRIER] &&
      !out_tdata[irpdt_pkg::OUT_REJECTED])
    else $error("frame_done outside the trailing gap");

  // A result follows every accepted input word.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word produced no result");

  // A last-byte load either starts the frame with the carrier on or is refused.
  a_start_mark: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == irpdt_pkg::OP_LOAD) && in_tlast |=>
      (out_tdata[irpdt_pkg::OUT_BUSY] && out_tdata[irpdt_pkg::OUT_CARRIER]) ||
      out_tdata[irpdt_pkg::OUT_REJECTED])
    else $error("frame start load neither started nor refused");

endmodule

bind ir_pulse_distance_transmitter irpdt_checker u_irpdt_checker (.*);

### tb/ir_pulse_distance_transmitter_chk.sv
// Scoreboard for the infrared pulse-distance transmitter: watches the input, result and
// configuration channels, predicts each result word and compares it field by field.
// Depends on irpdt_pkg.
module ir_pulse_distance_transmitter_chk #(
  parameter int unsigned STORE_DEPTH = irpdt_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [irpdt_pkg::DATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,   // last_byte
  input  logic                             in_tuser,   // [0] operation
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] carrier_enable, [1] busy_res, [2] frame_done, [3] load_rejected
  input  logic [irpdt_pkg::OUT_W-1:0]      out_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [irpdt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [irpdt_pkg::GAP_W-1:0]      cfg_data,
  output int                               mismatches,
  output int                               words_pending,
  output logic                             frame_running,
  output logic                             load_bounces,
  output int                               frames_sent,
  output int                               loads_refused
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GW = irpdt_pkg::GAP_W;
  localparam int unsigned TW = irpdt_pkg::TIME_W;

  typedef enum logic [6:0] {
    SEG_IDLE       = 7'b0000001,
    SEG_LEAD_MARK  = 7'b0000010,
    SEG_LEAD_SPACE = 7'b0000100,
    SEG_HDR_MARK   = 7'b0001000,
    SEG_BIT_SPACE  = 7'b0010000,
    SEG_BIT_MARK   = 7'b0100000,
    SEG_GAP        = 7'b1000000
  } seg_t;

  // Bit 0 is carrier_enable, matching the result word.
  typedef struct packed {
    logic rejected;
    logic done;
    logic busy;
    logic carrier;
  } ir_word_t;

  seg_t              seg;
  logic [GW-1:0]     remaining;
  logic [4:0]        nbytes;
  logic [4:0]        byte_pos;
  logic [2:0]        bit_pos;
  logic [7:0]        frame_bytes [STORE_DEPTH];

  logic [GW-1:0]     t_lead_mark, t_lead_space, t_hdr_mark;
  logic [GW-1:0]     t_one, t_zero, t_bit_mark, t_gap;

  ir_word_t          expected_words [$];
  int                errs;
  int                frames;
  int                refused;

  function automatic logic seg_is_mark(seg_t s);
    return s == SEG_LEAD_MARK || s == SEG_HDR_MARK || s == SEG_BIT_MARK;
  endfunction

  function automatic void enter_seg(seg_t s, logic [GW-1:0] len);
    seg       = s;
    remaining = len;
  endfunction

  function automatic void enter_bit_space();
    if (frame_bytes[byte_pos][bit_pos]) enter_seg(SEG_BIT_SPACE, t_one);
    else enter_seg(SEG_BIT_SPACE, t_zero);
  endfunction

  function automatic void write_timing(logic [irpdt_pkg::CFG_ADDR_W-1:0] idx,
                                       logic [GW-1:0] val);
    logic [GW-1:0] v16;
    v16 = GW'(val[TW-1:0]);
    case (idx)
      irpdt_pkg::REG_LEADER_MARK:  t_lead_mark  = v16;
      irpdt_pkg::REG_LEADER_SPACE: t_lead_space = v16;
      irpdt_pkg::REG_HEADER_MARK:  t_hdr_mark   = v16;
      irpdt_pkg::REG_ONE_SPACE:    t_one        = v16;
      irpdt_pkg::REG_ZERO_SPACE:   t_zero       = v16;
      irpdt_pkg::REG_BIT_MARK:     t_bit_mark   = v16;
      irpdt_pkg::REG_GAP:          t_gap        = val;
      default: ;
    endcase
  endfunction

  function automatic ir_word_t transmit_step(logic op, logic [7:0] b, logic last);
    ir_word_t r;
    r = '0;
    if (op == irpdt_pkg::OP_LOAD) begin
      if (seg != SEG_IDLE || nbytes >= STORE_DEPTH) begin
        r.rejected = 1'b1;
        refused++;
      end else begin
        frame_bytes[nbytes] = b;
        nbytes++;
        if (last) begin
          byte_pos = '0;
          bit_pos  = '0;
          enter_seg(SEG_LEAD_MARK, t_lead_mark);
        end
      end
      r.carrier = seg_is_mark(seg);
      r.busy    = seg != SEG_IDLE;
    end else if (seg != SEG_IDLE) begin
      r.carrier = seg_is_mark(seg);
      r.busy    = 1'b1;
      // a zero length still lasts one tick
      if (remaining > 1) begin
        remaining--;
      end else begin
        case (seg)
          SEG_LEAD_MARK:  enter_seg(SEG_LEAD_SPACE, t_lead_space);
          SEG_LEAD_SPACE: enter_seg(SEG_HDR_MARK, t_hdr_mark);
          SEG_HDR_MARK:   enter_bit_space();
          SEG_BIT_SPACE:  enter_seg(SEG_BIT_MARK, t_bit_mark);
          SEG_BIT_MARK: begin
            if (bit_pos == 3'd7) begin
              bit_pos = '0;
              byte_pos++;
            end else begin
              bit_pos++;
            end
            if (byte_pos >= nbytes) enter_seg(SEG_GAP, t_gap);
            else enter_bit_space();
          end
          default: begin
            r.done    = 1'b1;
            frames++;
            seg       = SEG_IDLE;
            remaining = '0;
            nbytes    = '0;
            byte_pos  = '0;
            bit_pos   = '0;
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic void check_bit(string field, logic want_b, logic got_b);
    if (got_b !== want_b) begin
      errs++;
      $error("%s: expected %0b, got %0b", field, want_b, got_b);
    end
  endfunction

  always @(posedge clk) begin
    ir_word_t want;
    if (!rst_n) begin
      seg          = SEG_IDLE;
      remaining    = '0;
      nbytes       = '0;
      byte_pos     = '0;
      bit_pos      = '0;
      t_lead_mark  = GW'(irpdt_pkg::RST_LEADER_MARK);
      t_lead_space = GW'(irpdt_pkg::RST_LEADER_SPACE);
      t_hdr_mark   = GW'(irpdt_pkg::RST_HEADER_MARK);
      t_one        = GW'(irpdt_pkg::RST_ONE_SPACE);
      t_zero       = GW'(irpdt_pkg::RST_ZERO_SPACE);
      t_bit_mark   = GW'(irpdt_pkg::RST_BIT_MARK);
      t_gap        = irpdt_pkg::RST_GAP;
      expected_words.delete();
      errs    = 0;
      frames  = 0;
      refused = 0;
    end else begin
      if (cfg_valid && cfg_ready) write_timing(cfg_addr, cfg_data);
      // results are registered and leave only after their word, so retire before predicting
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          errs++;
          $error("result word %h with nothing expected", out_tdata);
        end else begin
          want = expected_words.pop_front();
          check_bit("carrier_enable", want.carrier, out_tdata[irpdt_pkg::OUT_CARRIER]);
          check_bit("busy_res", want.busy, out_tdata[irpdt_pkg::OUT_BUSY]);
          check_bit("frame_done", want.done, out_tdata[irpdt_pkg::OUT_DONE]);
          check_bit("load_rejected", want.rejected, out_tdata[irpdt_pkg::OUT_REJECTED]);
          if (out_tdata[irpdt_pkg::OUT_W-1:irpdt_pkg::OUT_FLDS] !== '0) begin
            errs++;
            $error("padding: expected 0, got %h",
                   out_tdata[irpdt_pkg::OUT_W-1:irpdt_pkg::OUT_FLDS]);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_words.push_back(transmit_step(in_tuser, in_tdata, in_tlast));
    end
    mismatches    <= errs;
    words_pending <= expected_words.size();
    frame_running <= seg != SEG_IDLE;
    // one more word cannot end the frame, so a load after it still bounces
    load_bounces  <= seg != SEG_IDLE && !(seg == SEG_GAP && remaining <= 2);
    frames_sent   <= frames;
    loads_refused <= refused;
  end

endmodule

### tb/ir_pulse_distance_transmitter_tb.sv
// Testbench top for the infrared pulse-distance transmitter: clock, reset, stimulus on
// the frame and timing channels, and the verdict. Depends on irpdt_pkg, the block and
// ir_pulse_distance_transmitter_chk.
module ir_pulse_distance_transmitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GW = irpdt_pkg::GAP_W;
  localparam logic [irpdt_pkg::CFG_ADDR_W-1:0] REG_SPARE = 3'd7;
  localparam int RANDOM_WORDS   = 100;
  localparam int LONG_HOLD      = 300;
  localparam int STORE_DEPTH_TB = irpdt_pkg::MAX_FRAME_BYTES_DEF;

  typedef struct packed {
    logic [irpdt_pkg::CFG_ADDR_W-1:0] addr;
    logic [GW-1:0]                    data;
  } reg_write_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [irpdt_pkg::DATA_W-1:0]     in_tdata;
  logic                             in_tlast;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [irpdt_pkg::OUT_W-1:0]      out_tdata;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [irpdt_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [GW-1:0]                    cfg_data;

  int   mismatches;
  int   words_pending;
  logic frame_running;
  logic load_bounces;
  int   frames_sent;
  int   loads_refused;

  int         words_in;
  int         cfg_writes;
  int         sender_calm;
  bit         calm;
  bit         hold_req;
  reg_write_t reg_q [$];

  ir_pulse_distance_transmitter dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data
  );

  ir_pulse_distance_transmitter_chk chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data,
    .mismatches, .words_pending, .frame_running, .load_bounces,
    .frames_sent, .loads_refused
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: short random stalls, calm stretches, and one long hold on request.
  initial begin
    int  calm_left;
    bit  held;
    calm_left = 0;
    held      = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!calm && calm_left == 0 && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(50, 200);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_word(input logic op, input logic [7:0] b, input logic last);
    if (sender_calm > 0) begin
      sender_calm--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end else if ($urandom_range(0, 59) == 0) begin
      sender_calm = $urandom_range(40, 150);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    words_in++;
  endtask

  task automatic tick();
    push_word(irpdt_pkg::OP_TICK, 8'($urandom), 1'($urandom));
  endtask

  // Hold the input until every result is back and the frame is over.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0 || frame_running) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_regs();
    reg_write_t w;
    if (reg_q.size() == 0) return;
    while (reg_q.size() != 0) begin
      w = reg_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_addr  <= w.addr;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [GW-1:0] lm, input logic [GW-1:0] ls,
                            input logic [GW-1:0] hm, input logic [GW-1:0] os,
                            input logic [GW-1:0] zs, input logic [GW-1:0] bm,
                            input logic [GW-1:0] gap);
    reg_q.push_back('{irpdt_pkg::REG_LEADER_MARK, lm});
    reg_q.push_back('{irpdt_pkg::REG_LEADER_SPACE, ls});
    reg_q.push_back('{irpdt_pkg::REG_HEADER_MARK, hm});
    reg_q.push_back('{irpdt_pkg::REG_ONE_SPACE, os});
    reg_q.push_back('{irpdt_pkg::REG_ZERO_SPACE, zs});
    reg_q.push_back('{irpdt_pkg::REG_BIT_MARK, bm});
    reg_q.push_back('{irpdt_pkg::REG_GAP, gap});
    apply_regs();
  endtask

  // Short segment length; the upper nibble is junk the 16-bit registers drop.
  function automatic logic [GW-1:0] short_len(int unsigned hi);
    return {4'($urandom), 16'($urandom_range(0, hi))};
  endfunction

  task automatic random_timing();
    if ($urandom_range(0, 3) == 0) reg_q.push_back('{REG_SPARE, GW'($urandom)});
    set_timing(short_len(4), short_len(4), short_len(3), short_len(5), short_len(3),
               short_len(3), GW'($urandom_range(0, 6)));
  endtask

  // Load the frame, then tick it out; noisy frames also try loads while busy.
  task automatic send_frame(input logic [7:0] bytes [$], input bit noisy);
    for (int i = 0; i < bytes.size(); i++) begin
      if (noisy && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) tick();
      push_word(irpdt_pkg::OP_LOAD, bytes[i], i == bytes.size() - 1);
    end
    do begin
      if (noisy && load_bounces && $urandom_range(0, 11) == 0)
        push_word(irpdt_pkg::OP_LOAD, 8'($urandom), 1'($urandom));
      else
        tick();
    end while (frame_running);
  endtask

  initial begin
    logic [7:0] fb [$];
    int         start_words;
    int         nb;
    int         pick;
    int         frames_left;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    in_tuser    <= irpdt_pkg::OP_TICK;
    cfg_valid   <= 1'b0;
    cfg_addr    <= '0;
    cfg_data    <= '0;
    words_in    = 0;
    cfg_writes  = 0;
    sender_calm = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks, then short timings with a zero-length header and a spare index
    repeat (3) tick();
    settle();
    reg_q.push_back('{REG_SPARE, GW'($urandom)});
    set_timing(2, 1, 0, 3, 1, 1, 2);
    fb = {8'h00, 8'hff};
    send_frame(fb, 1'b0);
    // one tick per segment keeps the full-store frame short
    settle();
    set_timing(1, 1, 1, 1, 0, 1, 1);
    fb = {8'h01, 8'h80};
    for (int i = 0; i < 14; i++) fb.push_back(8'($urandom));
    send_frame(fb, 1'b1);
    settle();
    set_timing(1, 2, 1, 1, 3, 2, 0);
    fb = {8'h5a};
    send_frame(fb, 1'b1);

    // longer leader mark and one-bit space
    settle();
    set_timing(17, 1, 1, 9, 1, 1, 1);
    calm = 1'b1;
    fb = {8'h80};
    send_frame(fb, 1'b0);
    calm = 1'b0;

    settle();
    random_timing();
    hold_req    = 1'b1;
    frames_left = 4;
    start_words = words_in;
    while (words_in - start_words < RANDOM_WORDS) begin
      if (frames_left == 0) begin
        settle();
        random_timing();
        frames_left = 4;
      end
      pick = $urandom_range(0, 19);
      if (pick < 14) nb = $urandom_range(1, 3);
      else if (pick < 19) nb = $urandom_range(4, 8);
      else nb = $urandom_range(9, 16);
      fb = {};
      for (int i = 0; i < nb; i++) fb.push_back(8'($urandom));
      send_frame(fb, 1'b1);
      frames_left--;
    end

    // closing stretch without idling: one more frame, then widest timings and a full store
    calm = 1'b1;
    settle();
    random_timing();
    fb = {8'($urandom), 8'($urandom)};
    send_frame(fb, 1'b1);
    settle();
    reg_q.push_back('{REG_SPARE, '1});
    set_timing(65535, 65535, 65535, 65535, 65535, 65535, '1);
    repeat (STORE_DEPTH_TB) push_word(irpdt_pkg::OP_LOAD, 8'($urandom), 1'b0);
    push_word(irpdt_pkg::OP_LOAD, 8'($urandom), 1'b1);
    push_word(irpdt_pkg::OP_LOAD, 8'($urandom), 1'b0);
    repeat (3) tick();
    settle();

    $display("run covered %0d input words, %0d frames sent, %0d loads refused, %0d reg writes",
             words_in, frames_sent, loads_refused, cfg_writes);
    $display("timings from zero-length to full-width segments, ending on a full frame store");
    if (mismatches == 0 && words_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
sv/irpdt_pkg.sv
sv/irpdt_shifter.sv
sv/ir_pulse_distance_transmitter.sv
sv/irpdt_checker.sv
tb/ir_pulse_distance_transmitter_chk.sv
tb/ir_pulse_distance_transmitter_tb.sv
